// ===== hw/rtl/ccs_pkg.sv =====
// ----------------------------------------------------------------------------
// Crypto constant scanner package
// Item types, the constant table and default sizes for the scanner.
// ----------------------------------------------------------------------------
package ccs_pkg;

  localparam int unsigned MaxMatchesDefault = 10;
  localparam int unsigned RomSize           = 82;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } ccs_in_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] hit_value;
    logic [3:0]  hit_slot;
    logic        final_res;
    logic [3:0]  hit_count;
  } ccs_out_t;

  // TEA delta and negation, MD5 IV, SHA-1 K, SHA-256 IV and K
  localparam logic [31:0] ConstRom [RomSize] = '{
    32'h9E3779B9, 32'h61C88647,
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476,
    32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC, 32'hCA62C1D6,
    32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
    32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19,
    32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
    32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
    32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
    32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
    32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
    32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
    32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
    32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
    32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
    32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
    32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
    32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
    32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
    32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
    32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
    32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
  };

  function automatic logic in_rom(logic [31:0] word);
    logic found;
    found = 1'b0;
    for (int k = 0; k < RomSize; k++) begin
      found = found | (ConstRom[k] == word);
    end
    return found;
  endfunction

endpackage

// ===== hw/rtl/crypto_constant_scanner.sv =====
// ----------------------------------------------------------------------------
// Crypto constant scanner
// Scans a byte stream for well-known 32-bit cipher and hash constants.
// ----------------------------------------------------------------------------
// Pipeline: word register, then ROM compare into the result register; a
//   result that cannot enter the result register holds the word register.
// Throughput: one byte item per cycle while results can enter the result
//   register; the parallel compare with the 82 entry constant table allows it.
// Reset: asynchronous, active low; window, fill count, match count and all
//   valid flags cleared. The last byte of a buffer also clears the state.
module crypto_constant_scanner
  import ccs_pkg::*;
#(
  parameter int unsigned MaxMatches = MaxMatchesDefault
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  ccs_in_t  in_item_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output ccs_out_t out_item_o
);

  localparam int unsigned CntW = $clog2(MaxMatches + 1);

  // --- front end: sliding window, word register --------------------------
  logic [23:0] window_q, window_d;   // three previous bytes, oldest in [7:0]
  logic [1:0]  seen_q, seen_d;       // bytes held, saturates at three
  logic        s1_valid_q, s1_valid_d;
  logic [31:0] s1_word_q;
  logic        s1_full_q;            // window was complete for this word
  logic        s1_last_q;

  // --- compare stage ------------------------------------------------------
  logic [CntW-1:0] matches_q, matches_d;
  logic            recorded;
  logic            produce;
  logic            out_free;
  logic            s1_adv;
  logic            in_acc;
  logic [31:0]     new_word;
  logic [CntW+3:0] slot_ext, count_ext;
  logic [CntW-1:0] count_next;

  logic     out_valid_q, out_valid_d;
  ccs_out_t out_item_q, out_item_d;

  // Newest byte lands in the top of the little-endian word.
  assign new_word = {in_item_i.data_byte, window_q};

  // A word only counts once the match budget still has room.
  assign recorded   = s1_valid_q && s1_full_q && (matches_q < CntW'(MaxMatches))
                      && in_rom(s1_word_q);
  assign produce    = recorded || s1_last_q;
  assign out_free   = !out_valid_q || out_ready_i;
  // Items with nothing to report drain without touching the output register.
  assign s1_adv     = s1_valid_q && (!produce || out_free);
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_acc     = in_valid_i && in_ready_o;

  assign count_next = recorded ? matches_q + CntW'(1) : matches_q;
  assign slot_ext   = {4'b0, matches_q};
  assign count_ext  = {4'b0, count_next};

  always_comb begin
    window_d   = window_q;
    seen_d     = seen_q;
    s1_valid_d = s1_valid_q;
    if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
    if (in_acc) begin
      s1_valid_d = 1'b1;
      if (in_item_i.last_byte) begin
        window_d = '0;
        seen_d   = '0;
      end else begin
        window_d = new_word[31:8];
        seen_d   = (seen_q == 2'd3) ? seen_q : seen_q + 2'd1;
      end
    end
  end

  always_comb begin
    matches_d   = matches_q;
    out_valid_d = out_valid_q;
    out_item_d  = out_item_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (s1_adv) begin
      matches_d = s1_last_q ? '0 : count_next;
      if (produce) begin
        out_valid_d          = 1'b1;
        out_item_d.hit       = recorded;
        out_item_d.hit_value = recorded ? s1_word_q : '0;
        out_item_d.hit_slot  = recorded ? slot_ext[3:0] : '0;
        out_item_d.final_res = s1_last_q;
        out_item_d.hit_count = count_ext[3:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q    <= '0;
      seen_q      <= '0;
      s1_valid_q  <= 1'b0;
      matches_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      window_q    <= window_d;
      seen_q      <= seen_d;
      s1_valid_q  <= s1_valid_d;
      matches_q   <= matches_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers, no reset needed.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_word_q <= new_word;
      s1_full_q <= (seen_q == 2'd3);
      s1_last_q <= in_item_i.last_byte;
    end
    out_item_q <= out_item_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

// ===== tb/crypto_constant_scanner_checker.sv =====
// ----------------------------------------------------------------------------
// Crypto constant scanner checker
// Watches both item channels, predicts each result and compares field by field.
// ----------------------------------------------------------------------------
module crypto_constant_scanner_checker
  import ccs_pkg::*;
#(
  parameter int unsigned MaxMatches = MaxMatchesDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  ccs_in_t     in_item_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  ccs_out_t    out_item_i,
  output int unsigned pending_o,
  output int unsigned mismatches_o
);

  // independent copy of the signature table
  localparam int unsigned SigCount = 82;
  localparam logic [31:0] SignatureTable [SigCount] = '{
    32'h9E3779B9, 32'h61C88647,
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476,
    32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC, 32'hCA62C1D6,
    32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
    32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19,
    32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
    32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
    32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
    32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
    32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
    32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
    32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
    32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
    32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
    32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
    32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
    32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
    32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
    32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
    32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
    32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
  };

  logic [23:0]  win_q    = '0;  // three previous bytes, oldest at 7:0
  logic [1:0]   fill_cnt = '0;  // saturates at three
  int unsigned  hits_q   = 0;
  int unsigned  mismatches = 0;
  ccs_out_t     expected_results[$];

  assign mismatches_o = mismatches;

  function automatic logic is_signature(logic [31:0] word);
    logic found;
    found = 1'b0;
    foreach (SignatureTable[k]) begin
      if (SignatureTable[k] == word) found = 1'b1;
    end
    return found;
  endfunction

  task automatic report_mismatch(string msg);
    $display("%0t scan check: %s", $time, msg);
    mismatches++;
  endtask

  task automatic scan_step(ccs_in_t item);
    logic [31:0] word;
    logic        taken;
    ccs_out_t    res;
    word  = {item.data_byte, win_q};
    taken = (fill_cnt == 2'd3) && (hits_q < MaxMatches) && is_signature(word);
    res   = '0;
    if (taken) begin
      res.hit       = 1'b1;
      res.hit_value = word;
      res.hit_slot  = 4'(hits_q);
      hits_q++;
    end
    win_q = word[31:8];
    if (fill_cnt != 2'd3) fill_cnt++;
    if (taken || item.last_byte) begin
      res.final_res = item.last_byte;
      res.hit_count = 4'(hits_q);
      expected_results.push_back(res);
    end
    // end of buffer: back to the empty window
    if (item.last_byte) begin
      win_q    = '0;
      fill_cnt = '0;
      hits_q   = 0;
    end
  endtask

  task automatic check_result(ccs_out_t got);
    ccs_out_t want;
    if (expected_results.size() == 0) begin
      report_mismatch($sformatf("unexpected result %h", got));
      return;
    end
    want = expected_results.pop_front();
    if (got.hit !== want.hit)
      report_mismatch($sformatf("hit exp %0h got %0h", want.hit, got.hit));
    if (got.hit_value !== want.hit_value)
      report_mismatch($sformatf("hit_value exp %h got %h", want.hit_value, got.hit_value));
    if (got.hit_slot !== want.hit_slot)
      report_mismatch($sformatf("hit_slot exp %0d got %0d", want.hit_slot, got.hit_slot));
    if (got.final_res !== want.final_res)
      report_mismatch($sformatf("final_res exp %0h got %0h", want.final_res, got.final_res));
    if (got.hit_count !== want.hit_count)
      report_mismatch($sformatf("hit_count exp %0d got %0d", want.hit_count, got.hit_count));
  endtask

  // results are never caused by an item accepted at the same edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_i && out_ready_i) check_result(out_item_i);
      if (in_valid_i && in_ready_i) scan_step(in_item_i);
    end
    pending_o <= expected_results.size();
  end

endmodule

// ===== tb/crypto_constant_scanner_test.sv =====
// ----------------------------------------------------------------------------
// Crypto constant scanner testbench
// Directed and random byte buffers with embedded signatures, random gaps and
// result stalls; the checker beside the block scores every result.
// ----------------------------------------------------------------------------
module crypto_constant_scanner_test;
  import ccs_pkg::*;

  logic        clk_i;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  ccs_in_t     in_item_i   = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  ccs_out_t    out_item_o;

  int unsigned results_pending;
  int unsigned fail_count;

  // stimulus bookkeeping
  logic [7:0]  frame_bytes[$];
  int unsigned bytes_sent   = 0;
  bit          quiet_sender = 1'b0;

  // receiver stall state
  int unsigned stall_left = 0;
  int unsigned calm_left  = 0;
  int unsigned stall_roll;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  crypto_constant_scanner #(
    .MaxMatches (MaxMatchesDefault)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  crypto_constant_scanner_checker #(
    .MaxMatches (MaxMatchesDefault)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .in_item_i    (in_item_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_item_i   (out_item_o),
    .pending_o    (results_pending),
    .mismatches_o (fail_count)
  );

  // Result side back-pressure: mostly ready, short stalls now and then, the
  // odd long one, and calm stretches where ready never drops.
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      out_ready_i <= 1'b0;
      stall_left--;
    end else begin
      out_ready_i <= 1'b1;
      if (calm_left != 0) begin
        calm_left--;
      end else begin
        stall_roll = $urandom_range(0, 99);
        if (stall_roll < 10)      stall_left = $urandom_range(1, 3);
        else if (stall_roll < 12) stall_left = $urandom_range(10, 40);
        else if (stall_roll < 14) calm_left  = $urandom_range(50, 200);
      end
    end
  end

  // Sender gap before an item; mostly none or short, a few long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (quiet_sender) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  // Called just after a rising edge; returns just after the accepting edge.
  task automatic send_byte(logic [7:0] data, logic last);
    int unsigned gap;
    ccs_in_t     item;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    item.data_byte = data;
    item.last_byte = last;
    in_valid_i <= 1'b1;
    in_item_i  <= item;
    do @(posedge clk_i); while (!in_ready_o);
    bytes_sent++;
  endtask

  // Sends the queued buffer, last flag on its final byte, then empties it.
  task automatic send_frame();
    for (int k = 0; k < frame_bytes.size(); k++) begin
      send_byte(frame_bytes[k], k == frame_bytes.size() - 1);
    end
    frame_bytes.delete();
  endtask

  // Little-endian: the first byte sent is the least significant one, so a
  // partial push gives a truncated signature that must not match.
  task automatic push_const(int unsigned idx, int unsigned nbytes);
    logic [31:0] word;
    word = ConstRom[idx];
    for (int k = 0; k < nbytes; k++) frame_bytes.push_back(word[8*k +: 8]);
  endtask

  task automatic push_noise(int unsigned n);
    repeat (n) frame_bytes.push_back(8'($urandom_range(0, 255)));
  endtask

  // Random buffer: short ones, dense ones that run past the match limit,
  // and mixed ones with signatures, broken signatures and noise.
  task automatic build_random_frame();
    int unsigned kind;
    int unsigned nseg;
    int unsigned roll;
    kind = $urandom_range(0, 99);
    if (kind < 6) begin
      push_noise($urandom_range(1, 3));
    end else if (kind < 20) begin
      nseg = $urandom_range(MaxMatchesDefault + 1, MaxMatchesDefault + 6);
      repeat (nseg) begin
        push_const($urandom_range(0, RomSize - 1), 4);
        if ($urandom_range(0, 3) == 0) push_noise(1);
      end
    end else begin
      nseg = $urandom_range(1, 8);
      repeat (nseg) begin
        roll = $urandom_range(0, 99);
        if (roll < 45)      push_const($urandom_range(0, RomSize - 1), 4);
        else if (roll < 55) push_const($urandom_range(0, RomSize - 1), $urandom_range(1, 3));
        else                push_noise($urandom_range(1, 6));
      end
      // often finish on a signature so the final item carries a hit
      if ($urandom_range(0, 9) < 4) push_const($urandom_range(0, RomSize - 1), 4);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // single byte buffer, all ones
    frame_bytes.push_back(8'hFF);
    send_frame();
    // two bytes, both extremes
    frame_bytes.push_back(8'h00);
    frame_bytes.push_back(8'hFF);
    send_frame();
    // three bytes of a signature: window never fills, so no hit
    frame_bytes.push_back(8'h79);
    frame_bytes.push_back(8'h37);
    frame_bytes.push_back(8'h9E);
    send_frame();
    // first signature of the table on the final item
    push_const(0, 4);
    send_frame();
    // two hits mid-buffer, then a final item without one
    push_const(10, 4);
    push_const(18, 4);
    frame_bytes.push_back(8'h00);
    send_frame();
    // last signature of the table on the final item
    push_const(RomSize - 1, 4);
    send_frame();

    // random buffers until at least 1270 items have gone in
    while (bytes_sent < 1270) begin
      quiet_sender = ($urandom_range(0, 4) == 0);
      build_random_frame();
      send_frame();
    end
    in_valid_i <= 1'b0;

    // drain, then allow for any stray late result
    do @(posedge clk_i); while (results_pending != 0);
    repeat (10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // watchdog: well beyond the slowest legal run
  initial begin
    #20000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/ccs_pkg.sv
hw/rtl/crypto_constant_scanner.sv
tb/crypto_constant_scanner_checker.sv
tb/crypto_constant_scanner_test.sv
